// ===== sv/pced_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pced_pkg;

  // Port widths of the coordinate and distance fields.
  localparam int IN_W  = 16;
  localparam int OUT_W = 17;

  typedef struct packed {
    logic signed [IN_W-1:0] px;
    logic signed [IN_W-1:0] py;
    logic signed [IN_W-1:0] pz;
    logic                   final_point;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] width;
    logic [OUT_W-1:0] length;
  } out_t;

endpackage

`default_nettype wire

// ===== sv/pced_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pced_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/pced_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pced_front #(
  parameter int CB = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output logic                 full,
  input  wire pced_pkg::in_t   in_data,
  output logic                 job_push,
  input  wire logic            job_full,
  output logic [12*CB-1:0]     job_data
);

  localparam int PW = 3 * CB;

  logic signed [CB-1:0] p_x;
  logic signed [CB-1:0] p_y;
  logic signed [CB-1:0] p_z;
  logic                 accept;
  logic                 empty_r;
  logic [3:0]           take;

  logic signed [CB-1:0] ex_x_r   [4];
  logic signed [CB-1:0] ex_y_r   [4];
  logic signed [CB-1:0] ex_z_r   [4];
  logic signed [CB-1:0] ex_x_nxt [4];
  logic signed [CB-1:0] ex_y_nxt [4];
  logic signed [CB-1:0] ex_z_nxt [4];

  // Coordinates are the low CB bits of each field, zero-extended when CB is wider than the field.
  if (CB <= pced_pkg::IN_W) begin : g_narrow
    assign p_x = in_data.px[CB-1:0];
    assign p_y = in_data.py[CB-1:0];
    assign p_z = in_data.pz[CB-1:0];
  end else begin : g_wide
    assign p_x = {{(CB - pced_pkg::IN_W){1'b0}}, in_data.px};
    assign p_y = {{(CB - pced_pkg::IN_W){1'b0}}, in_data.py};
    assign p_z = {{(CB - pced_pkg::IN_W){1'b0}}, in_data.pz};
  end

  assign full     = job_full;
  assign accept   = push && !full;
  assign job_push = accept && in_data.final_point;

  // Strict compares, so the earliest point keeps its place on a tie.
  assign take[0] = empty_r || (p_x < ex_x_r[0]);
  assign take[1] = empty_r || (p_x > ex_x_r[1]);
  assign take[2] = empty_r || (p_z < ex_z_r[2]);
  assign take[3] = empty_r || (p_z > ex_z_r[3]);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ex_x_nxt[k] = take[k] ? p_x : ex_x_r[k];
      ex_y_nxt[k] = take[k] ? p_y : ex_y_r[k];
      ex_z_nxt[k] = take[k] ? p_z : ex_z_r[k];
    end
  end

  // The job holds the four updated extremes: least x, greatest x, least z, greatest z.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      job_data[k*PW +: PW] = {ex_z_nxt[k], ex_y_nxt[k], ex_x_nxt[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 4; k++) begin
        ex_x_r[k] <= ex_x_nxt[k];
        ex_y_r[k] <= ex_y_nxt[k];
        ex_z_r[k] <= ex_z_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_r <= 1'b1;
    end else if (accept) begin
      empty_r <= in_data.final_point;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pced_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pced_back #(
  parameter int CB = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_empty,
  input  wire logic [12*CB-1:0]  job_data,
  output logic                   job_pop,
  output logic                   empty,
  input  wire logic              pop,
  output pced_pkg::out_t         out_data
);

  localparam int PW    = 3 * CB;
  localparam int RW    = CB + 1;
  localparam int AW    = 2 * CB + 2;
  localparam int REMW  = CB + 3;
  localparam int CTR_W = $clog2(CB + 2);
  localparam int OW    = pced_pkg::OUT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SQ    = 4'b0010,
    S_ROOT  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t             state_r;
  logic               pair_r;
  logic [CTR_W-1:0]   cnt_r;
  logic [CB-1:0]      diff_r;
  logic [2*CB-1:0]    sq_r;
  logic [AW-1:0]      acc_r;
  logic [REMW-1:0]    rem_r;
  logic [RW-1:0]      root_r;
  logic [RW-1:0]      width_r;
  logic               res_valid_r;
  pced_pkg::out_t     res_r;

  logic [PW-1:0]      a_pt;
  logic [PW-1:0]      b_pt;
  logic [CB-1:0]      a_c;
  logic [CB-1:0]      b_c;
  logic signed [CB:0] diff_s;
  logic signed [CB:0] diff_mag;
  logic [2*CB-1:0]    sq_nxt;
  logic [REMW-1:0]    rem_sh;
  logic [REMW-1:0]    trial;
  logic               ge;
  logic [REMW-1:0]    rem_nxt;
  logic [RW-1:0]      root_nxt;
  logic [OW-1:0]      width_o;
  logic [OW-1:0]      length_o;
  logic               wr_ok;

  assign a_pt = pair_r ? job_data[2*PW +: PW] : job_data[0 +: PW];
  assign b_pt = pair_r ? job_data[3*PW +: PW] : job_data[PW +: PW];

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    begin a_c = a_pt[0 +: CB];    b_c = b_pt[0 +: CB];    end
      2'd1:    begin a_c = a_pt[CB +: CB];   b_c = b_pt[CB +: CB];   end
      default: begin a_c = a_pt[2*CB +: CB]; b_c = b_pt[2*CB +: CB]; end
    endcase
  end

  assign diff_s   = signed'({a_c[CB-1], a_c}) - signed'({b_c[CB-1], b_c});
  assign diff_mag = diff_s[CB] ? -diff_s : diff_s;
  assign sq_nxt   = diff_r * diff_r;

  // One result bit per cycle, restoring square root.
  assign rem_sh   = {rem_r[REMW-3:0], acc_r[AW-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign ge       = (rem_sh >= trial);
  assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
  assign root_nxt = {root_r[RW-2:0], ge};

  if (RW >= OW) begin : g_trunc
    assign width_o  = width_r[OW-1:0];
    assign length_o = root_r[OW-1:0];
  end else begin : g_ext
    assign width_o  = {{(OW - RW){1'b0}}, width_r};
    assign length_o = {{(OW - RW){1'b0}}, root_r};
  end

  assign wr_ok    = !res_valid_r || pop;
  assign job_pop  = (state_r == S_WRITE) && wr_ok;
  assign empty    = !res_valid_r;
  assign out_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pair_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!job_empty) begin
            state_r <= S_SQ;
            pair_r  <= 1'b0;
            cnt_r   <= '0;
          end
        end
        S_SQ: begin
          if (cnt_r == CTR_W'(4)) begin
            state_r <= S_ROOT;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_ROOT: begin
          if (cnt_r == CTR_W'(CB)) begin
            cnt_r <= '0;
            if (!pair_r) begin
              pair_r  <= 1'b1;
              state_r <= S_SQ;
            end else begin
              state_r <= S_WRITE;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_WRITE: begin
          if (wr_ok) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: difference, then square, then accumulate, one stage apart.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      acc_r <= '0;
    end else if (state_r == S_SQ) begin
      if (cnt_r < CTR_W'(3)) begin
        diff_r <= diff_mag[CB-1:0];
      end
      if ((cnt_r >= CTR_W'(1)) && (cnt_r <= CTR_W'(3))) begin
        sq_r <= sq_nxt;
      end
      if (cnt_r >= CTR_W'(2)) begin
        acc_r <= acc_r + AW'(sq_r);
      end
      if (cnt_r == CTR_W'(4)) begin
        rem_r  <= '0;
        root_r <= '0;
      end
    end else if (state_r == S_ROOT) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      acc_r  <= {acc_r[AW-3:0], 2'b00};
      if ((cnt_r == CTR_W'(CB)) && !pair_r) begin
        width_r <= root_nxt;
        acc_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      res_r.width  <= width_o;
      res_r.length <= length_o;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (job_pop) begin
      res_valid_r <= 1'b1;
    end else if (pop) begin
      res_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/point_cloud_extent_distances.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                       Transfer when        Carries
// input     push, full, in_data         push && !full        one point, final flag
// result    empty, pop, out_data        pop && !empty        width and length of a cloud
//
// Points are taken one per cycle while the job queue has room; the extremes are updated in the same cycle.
// The distance engine works on one cloud at a time, with a bit-serial square root
// that runs once for each of the two distances.
// Up to JOB_DEPTH finished clouds, the one in the engine included, sit in the job
// queue; full rises only when that queue is full, and a waiting result on the
// output does not stop the engine until it has the next one ready.
// Reset is synchronous and needs no clearing pass.

module point_cloud_extent_distances #(
  parameter int COORD_BITS = 16,
  parameter int JOB_DEPTH  = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  output logic                full,
  input  wire pced_pkg::in_t  in_data,
  output logic                empty,
  input  wire logic           pop,
  output pced_pkg::out_t      out_data
);

  localparam int JOB_W = 12 * COORD_BITS;

  // Front to engine: the four extreme points of each finished cloud.
  logic             job_push;
  logic             job_full;
  logic [JOB_W-1:0] job_wdata;
  logic [JOB_W-1:0] job_rdata;
  logic             job_empty;
  logic             job_pop;

  pced_front #(
    .CB (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .job_push (job_push),
    .job_full (job_full),
    .job_data (job_wdata)
  );

  pced_fifo #(
    .W     (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_wdata),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_rdata),
    .empty   (job_empty)
  );

  // The engine reads the job at the head of the queue in place and pops it
  // only when the result register takes the distances.
  pced_back #(
    .CB (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_data  (job_rdata),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

  // The front must never hand over a cloud while the queue has no room.
  a_no_job_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("cloud handed over while job queue full");

  // The engine only retires a cloud that is really queued.
  a_pop_needs_job : assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !job_empty)
    else $error("engine retired a cloud from an empty queue");

  // A final point taken into an empty queue leaves a cloud waiting.
  a_final_queues : assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && in_data.final_point && job_empty) |=> !job_empty)
    else $error("final point did not queue a cloud");

  // A new result can only appear when the engine retires a cloud.
  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(empty) |-> $past(job_pop))
    else $error("result appeared without a retired cloud");

endmodule

`default_nettype wire

// ===== tb/cloud_extent_checker.sv =====
`timescale 1ns / 1ps

module cloud_extent_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic           full,
  input  pced_pkg::in_t  in_data,
  input  logic           empty,
  input  logic           pop,
  input  pced_pkg::out_t out_data,
  output int             mismatches,
  output int             dims_pending
);

  typedef struct packed {
    logic signed [pced_pkg::IN_W-1:0] x;
    logic signed [pced_pkg::IN_W-1:0] y;
    logic signed [pced_pkg::IN_W-1:0] z;
  } point_t;

  typedef enum int {MIN_X, MAX_X, MIN_Z, MAX_Z} extreme_e;

  point_t         extremes [4];
  logic           cloud_open = 1'b0;
  pced_pkg::out_t expected_dims [$];
  int             err_cnt = 0;
  int             pending_cnt = 0;

  assign mismatches   = err_cnt;
  assign dims_pending = pending_cnt;

  // Floor of the Euclidean distance, found one result bit at a time.
  function automatic logic [pced_pkg::OUT_W-1:0] floor_dist(point_t a, point_t b);
    longint dx, dy, dz, sq, root, trial;
    int bitpos;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    sq = dx * dx + dy * dy + dz * dz;
    root = 0;
    for (bitpos = pced_pkg::OUT_W - 1; bitpos >= 0; bitpos--) begin
      trial = root | (longint'(1) << bitpos);
      if (trial * trial <= sq) root = trial;
    end
    return root[pced_pkg::OUT_W-1:0];
  endfunction

  task automatic clear_extremes();
    foreach (extremes[i]) extremes[i] = '0;
    cloud_open = 1'b0;
  endtask

  task automatic flag_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // Folds one accepted point into the kept extremes and, on the final
  // point of a cloud, queues the width and length the block must produce.
  task automatic take_point(pced_pkg::in_t item);
    point_t         p;
    pced_pkg::out_t dims;
    p = '{x: item.px, y: item.py, z: item.pz};
    if (!cloud_open) begin
      extremes[MIN_X] = p;
      extremes[MAX_X] = p;
      extremes[MIN_Z] = p;
      extremes[MAX_Z] = p;
      cloud_open = 1'b1;
    end else begin
      if (p.x < extremes[MIN_X].x) extremes[MIN_X] = p;
      if (p.x > extremes[MAX_X].x) extremes[MAX_X] = p;
      if (p.z < extremes[MIN_Z].z) extremes[MIN_Z] = p;
      if (p.z > extremes[MAX_Z].z) extremes[MAX_Z] = p;
    end
    if (item.final_point) begin
      dims.width  = floor_dist(extremes[MIN_X], extremes[MAX_X]);
      dims.length = floor_dist(extremes[MIN_Z], extremes[MAX_Z]);
      expected_dims = {expected_dims, dims};
      clear_extremes();
    end
  endtask

  always @(posedge clk) begin : watch
    pced_pkg::out_t want;
    if (!rst_n) begin
      clear_extremes();
      expected_dims.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_dims.size() == 0) begin
          flag_mismatch($sformatf("result width=%0d length=%0d with none expected",
                                  out_data.width, out_data.length));
        end else begin
          want = expected_dims.pop_front();
          if (out_data.width !== want.width)
            flag_mismatch($sformatf("width %0d, expected %0d", out_data.width, want.width));
          if (out_data.length !== want.length)
            flag_mismatch($sformatf("length %0d, expected %0d",
                                    out_data.length, want.length));
        end
      end
      if (push && !full) take_point(in_data);
    end
    pending_cnt = expected_dims.size();
  end

endmodule

// ===== tb/point_cloud_extent_distances_tb.sv =====
`timescale 1ns / 1ps

module point_cloud_extent_distances_tb;

  // The slowest correct run has every point closing a cloud, so each one
  // costs a full engine pass plus the longest sender gap and pop stall.
  // For 800 points that stays far below the limit.
  localparam int LIMIT        = 500000;
  localparam int TOTAL_POINTS = 800;
  localparam int TAIL_POINTS  = 120;
  localparam int SETTLE       = 100;

  typedef enum int {SPAN_FULL, SPAN_NEAR, SPAN_EDGE} coord_mode_e;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           push      = 1'b0;
  logic           pop       = 1'b0;
  pced_pkg::in_t  in_data   = '0;
  logic           calm_tail = 1'b0;
  logic           full;
  logic           empty;
  pced_pkg::out_t out_data;
  int             mismatches;
  int             dims_pending;
  int             cycle_cnt   = 0;
  int             points_sent = 0;

  point_cloud_extent_distances dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  // The checker sees every transfer on both channels, predicts each cloud's
  // width and length, and compares them in order with what comes out.
  cloud_extent_checker u_extent_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_data      (in_data),
    .empty        (empty),
    .pop          (pop),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .dims_pending (dims_pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic pced_pkg::in_t make_point(int x, int y, int z, bit last);
    pced_pkg::in_t p;
    p.px          = x[pced_pkg::IN_W-1:0];
    p.py          = y[pced_pkg::IN_W-1:0];
    p.pz          = z[pced_pkg::IN_W-1:0];
    p.final_point = last;
    return p;
  endfunction

  // Full-range values reach every bit; near values crowd around zero so that
  // extremes change often; edge values hit the limits and make many ties.
  function automatic logic signed [pced_pkg::IN_W-1:0] rand_coord(coord_mode_e mode);
    logic signed [pced_pkg::IN_W-1:0] v;
    case (mode)
      SPAN_FULL: v = pced_pkg::IN_W'($urandom);
      SPAN_NEAR: v = pced_pkg::IN_W'(int'($urandom_range(0, 64)) - 32);
      default: begin
        case ($urandom_range(0, 4))
          0:       v = {1'b1, {(pced_pkg::IN_W-1){1'b0}}};
          1:       v = {1'b0, {(pced_pkg::IN_W-1){1'b1}}};
          2:       v = '0;
          3:       v = '1;
          default: v = pced_pkg::IN_W'($urandom);
        endcase
      end
    endcase
    return v;
  endfunction

  // Holds push high until the block takes the point. push is left high, so a
  // following point goes out back to back unless a gap is inserted.
  task automatic send_point(pced_pkg::in_t p);
    push    <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    points_sent++;
  endtask

  // Sometimes the sender goes quiet for a short burst, except in the tail.
  task automatic sender_breather();
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted result has been popped.
  // The pending count is read at the falling edge, clear of the update.
  task automatic wait_for_results();
    push <= 1'b0;
    @(negedge clk);
    while (dims_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Result side: pop is high most of the time, with random stall bursts
  // that stop once the tail of the run begins.
  initial begin : result_drain
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    pced_pkg::in_t directed [$];
    int            cloud_len;
    int            k;
    coord_mode_e   mode;
    coord_mode_e   pt_mode;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = {
      // A cloud of one point at the top corner, then one at the bottom.
      make_point(32767, 32767, 32767, 1'b1),
      make_point(-32768, -32768, -32768, 1'b1),
      // Opposite corners: the largest distance the fields allow.
      make_point(-32768, -32768, -32768, 1'b0),
      make_point(32767, 32767, 32767, 1'b1),
      // Equal x and z throughout: the first point must stay every extreme.
      make_point(100, 7, -50, 1'b0),
      make_point(100, -7, -50, 1'b0),
      make_point(100, 300, -50, 1'b1),
      // Distinct extremes, all but the least z later tied by a point that differs in y.
      make_point(0, 0, 0, 1'b0),
      make_point(-5, 0, 0, 1'b0),
      make_point(10, 0, 0, 1'b0),
      make_point(-5, 999, 0, 1'b0),
      make_point(10, -999, 0, 1'b0),
      make_point(0, 0, 8, 1'b0),
      make_point(0, 0, -8, 1'b0),
      make_point(0, 5, 8, 1'b1),
      // Alternating bit patterns in every coordinate.
      make_point(21845, -21846, 21845, 1'b0),
      make_point(-21846, 21845, -21846, 1'b1),
      // The origin alone.
      make_point(0, 0, 0, 1'b1)
    };
    foreach (directed[i]) begin
      send_point(directed[i]);
      sender_breather();
    end
    // Let the engine empty out completely once before the random part.
    wait_for_results();

    while (points_sent < TOTAL_POINTS) begin
      case ($urandom_range(0, 19))
        0:             cloud_len = 1;
        1, 2, 3, 4:    cloud_len = $urandom_range(11, 30);
        default:       cloud_len = $urandom_range(2, 10);
      endcase
      mode = coord_mode_e'($urandom_range(0, 2));
      for (k = 0; k < cloud_len; k++) begin
        calm_tail = (points_sent >= TOTAL_POINTS - TAIL_POINTS);
        pt_mode   = ($urandom_range(0, 7) == 0) ? SPAN_FULL : mode;
        send_point(make_point(rand_coord(pt_mode), rand_coord(pt_mode),
                              rand_coord(pt_mode), k == cloud_len - 1));
        sender_breather();
      end
      // Now and then a full drain between clouds, so new clouds also start
      // against an idle engine.
      if (!calm_tail && $urandom_range(0, 14) == 0) wait_for_results();
    end

    wait_for_results();
    // Room for a stray extra result to show up and be flagged.
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && dims_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
